FILE: rtl/core/tar_stream_deframer_top_defines.svh
// Assertion macros for the checker file of the deframer.
`ifndef TAR_STREAM_DEFRAMER_TOP_DEFINES_SVH
`define TAR_STREAM_DEFRAMER_TOP_DEFINES_SVH

// Property checked on every rising clock edge outside reset.
`define TSD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Property checked on every rising clock edge, reset included.
`define TSD_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

FILE: rtl/core/tsd_pkg.sv
package tsd_pkg;

  // Header block geometry.
  localparam int unsigned SizeDigits = 12;
  localparam int unsigned OffW       = 9;
  localparam int unsigned SizeW      = 36;

  localparam logic [OffW-1:0] SizeAt    = 9'd124;
  localparam logic [OffW-1:0] SizeEnd   = 9'(124 + SizeDigits);
  localparam logic [OffW-1:0] TypeAt    = 9'd156;
  localparam logic [OffW-1:0] LinkAt    = 9'd157;
  localparam logic [OffW-1:0] LinkEnd   = 9'd257;
  localparam logic [OffW-1:0] PrefixAt  = 9'd345;
  localparam logic [OffW-1:0] PrefixEnd = 9'd500;
  localparam logic [OffW-1:0] NameEnd   = 9'd100;
  localparam logic [OffW-1:0] LastOff   = 9'd511;

  // Characters of interest.
  localparam logic [7:0] ChNul   = 8'h00;
  localparam logic [7:0] ChTab   = 8'h09;
  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChZero  = 8'h30;
  localparam logic [7:0] ChSeven = 8'h37;
  localparam logic [7:0] ChLong  = 8'h4C;

  // Stream widths.
  localparam int unsigned TDataW = 64;
  localparam int unsigned TUserW = 4;

  typedef enum logic [3:0] {
    PH_HEADER = 4'b0001,
    PH_DATA   = 4'b0010,
    PH_PAD    = 4'b0100,
    PH_DONE   = 4'b1000
  } phase_e;

  typedef enum logic [1:0] {
    KIND_HEADER  = 2'd0,
    KIND_DATA    = 2'd1,
    KIND_PAD     = 2'd2,
    KIND_IGNORED = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    REG_OTHER  = 2'd0,
    REG_NAME   = 2'd1,
    REG_LINK   = 2'd2,
    REG_PREFIX = 2'd3
  } region_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_OVERRUN = 2'd1,
    ST_PARTIAL = 2'd2
  } status_e;

  typedef struct packed {
    phase_e            phase;
    logic [OffW-1:0]   block_offset;
    logic [SizeW-1:0]  size_acc;
    logic              octal_stopped;
    logic              all_zero;
    logic [7:0]        type_byte;
    logic [SizeW-1:0]  data_rem;
    logic [OffW-1:0]   pad_rem;
  } state_t;

  typedef struct packed {
    logic [7:0]        byte_out;
    kind_e             kind;
    region_e           region;
    logic              header_done;
    logic [SizeW-1:0]  entry_size;
    logic [7:0]        entry_type;
    logic              long_name;
    logic              archive_end;
    status_e           status;
  } result_t;

  localparam state_t StateReset = '{
    phase:         PH_HEADER,
    block_offset:  '0,
    size_acc:      '0,
    octal_stopped: 1'b0,
    all_zero:      1'b1,
    type_byte:     '0,
    data_rem:      '0,
    pad_rem:       '0
  };

endpackage

FILE: rtl/core/tsd_step.sv
module tsd_step (
  input  tsd_pkg::state_t  state_i,
  input  logic [7:0]       byte_i,
  input  logic             end_i,
  output tsd_pkg::state_t  state_o,
  output tsd_pkg::result_t result_o
);
  import tsd_pkg::*;

  logic [OffW-1:0]  off;
  logic             in_size;
  logic             all_zero_n;
  logic [SizeW-1:0] sz;
  logic [7:0]       etype;
  logic [SizeW-1:0] rem_n;
  logic [OffW-1:0]  pad_n;

  assign off        = state_i.block_offset;
  assign in_size    = (off >= SizeAt) && (off < SizeEnd) && !state_i.octal_stopped;
  assign all_zero_n = state_i.all_zero && (byte_i == ChNul);
  assign sz         = state_i.size_acc;
  assign etype      = (state_i.type_byte == ChNul) ? ChZero : state_i.type_byte;
  assign rem_n      = (state_i.data_rem != '0) ? state_i.data_rem - 36'd1 : state_i.data_rem;
  assign pad_n      = (state_i.pad_rem != '0) ? state_i.pad_rem - 9'd1 : state_i.pad_rem;

  // One archive byte: classify it and advance the block state.
  always_comb begin
    state_o             = state_i;
    result_o            = '0;
    result_o.byte_out   = byte_i;
    result_o.kind       = KIND_HEADER;
    result_o.region     = REG_OTHER;
    result_o.status     = ST_OK;

    case (state_i.phase)
      PH_HEADER: begin
        // Path region of this header byte.
        if (off < NameEnd) begin
          result_o.region = REG_NAME;
        end else if (off >= LinkAt && off < LinkEnd) begin
          result_o.region = REG_LINK;
        end else if (off >= PrefixAt && off < PrefixEnd) begin
          result_o.region = REG_PREFIX;
        end
        state_o.all_zero = all_zero_n;

        // Octal size digits; blanks are skipped, anything else stops the parse.
        if (in_size) begin
          if (byte_i == ChNul) begin
            state_o.octal_stopped = 1'b1;
          end else if (byte_i == ChSpace || byte_i == ChTab) begin
            state_o.octal_stopped = state_i.octal_stopped;
          end else if (byte_i < ChZero || byte_i > ChSeven) begin
            state_o.octal_stopped = 1'b1;
          end else begin
            state_o.size_acc = {sz[SizeW-4:0], 3'b000} + {33'd0, byte_i[2:0]};
          end
        end
        if (off == TypeAt) begin
          state_o.type_byte = byte_i;
        end

        if (off == LastOff) begin
          if (all_zero_n) begin
            result_o.archive_end = 1'b1;
            state_o.phase        = PH_DONE;
          end else begin
            result_o.header_done = 1'b1;
            result_o.entry_size  = sz;
            result_o.entry_type  = etype;
            result_o.long_name   = (etype == ChLong);
            if (end_i && sz != '0) begin
              result_o.status = ST_OVERRUN;
            end
            state_o.data_rem = sz;
            state_o.pad_rem  = 9'(10'd512 - {1'b0, sz[OffW-1:0]});
            state_o.phase    = (sz != '0) ? PH_DATA : PH_HEADER;
          end
          // Header bookkeeping starts over for the next block.
          state_o.block_offset  = '0;
          state_o.size_acc      = '0;
          state_o.octal_stopped = 1'b0;
          state_o.all_zero      = 1'b1;
          state_o.type_byte     = '0;
        end else begin
          state_o.block_offset = off + 9'd1;
          if (end_i) begin
            result_o.status = ST_PARTIAL;
          end
        end
      end
      PH_DATA: begin
        result_o.kind = KIND_DATA;
        if (end_i && state_i.data_rem > 36'd1) begin
          result_o.status = ST_OVERRUN;
        end
        state_o.data_rem = rem_n;
        if (rem_n == '0) begin
          state_o.phase = (state_i.pad_rem != '0) ? PH_PAD : PH_HEADER;
        end
      end
      PH_PAD: begin
        result_o.kind   = KIND_PAD;
        state_o.pad_rem = pad_n;
        if (pad_n == '0) begin
          state_o.phase = PH_HEADER;
        end
      end
      default: begin
        result_o.kind = KIND_IGNORED;
      end
    endcase

    // The last byte of a stream returns everything to the reset state.
    if (end_i) begin
      state_o = StateReset;
    end
  end

endmodule

FILE: rtl/core/tar_stream_deframer_top.sv
// Tar archive deframer.
// The slave channel takes one archive byte per transaction in s_axis_tdata_i[7:0];
// s_axis_tlast_i marks the final byte of the archive. The master channel returns one
// transaction per input byte: the byte itself, its kind and header path region in
// tuser, and on the last byte of a header the parsed size, type and long-name flag.
// An all-zero header raises archive_end, and later bytes come back marked as ignored.
// A byte accepted is held in the input register, and its result is loaded into the
// output register once that register is empty or being drained. Throughput is one
// byte per cycle while the receiver keeps up, carried by the combinational update of
// the header, data and padding counters and the octal shift-add.
// Reset clears both registers and starts a new archive at a header block; the
// block also starts over after every byte that carries tlast.
// When the receiver stalls, the result waits in the output register, one more byte
// waits in the input register, and s_axis_tready_o falls until the output moves.
module tar_stream_deframer_top (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       s_axis_tvalid_i,
  output logic                       s_axis_tready_o,
  // [7:0] data_byte
  input  logic [7:0]                 s_axis_tdata_i,
  input  logic                       s_axis_tlast_i,
  output logic                       m_axis_tvalid_o,
  input  logic                       m_axis_tready_i,
  // [7:0] byte_out, [8] header_done, [44:9] entry_size, [52:45] entry_type,
  // [53] long_name, [54] archive_end, [56:55] status, [63:57] zero
  output logic [tsd_pkg::TDataW-1:0] m_axis_tdata_o,
  // [1:0] byte_kind, [3:2] header_region
  output logic [tsd_pkg::TUserW-1:0] m_axis_tuser_o
);
  import tsd_pkg::*;

  logic       in_valid_q;
  logic [7:0] in_byte_q;
  logic       in_end_q;
  state_t     state_q, state_d;
  logic       out_valid_q;
  result_t    out_q, result_d;
  logic       advance;

  // A stored byte moves on when the output register is empty or being drained.
  assign advance         = in_valid_q && (!out_valid_q || m_axis_tready_i);
  assign s_axis_tready_o = !in_valid_q || advance;

  tsd_step u_step (
    .state_i  (state_q),
    .byte_i   (in_byte_q),
    .end_i    (in_end_q),
    .state_o  (state_d),
    .result_o (result_d)
  );

  // Input register control.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      in_valid_q <= s_axis_tvalid_i;
    end
  end

  // Input register payload.
  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid_i && s_axis_tready_o) begin
      in_byte_q <= s_axis_tdata_i[7:0];
      in_end_q  <= s_axis_tlast_i;
    end
  end

  // Parser state and output valid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StateReset;
      out_valid_q <= 1'b0;
    end else begin
      if (advance) begin
        state_q <= state_d;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Output register payload.
  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_q <= result_d;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {7'd0, out_q.status, out_q.archive_end, out_q.long_name,
                            out_q.entry_type, out_q.entry_size, out_q.header_done,
                            out_q.byte_out};
  assign m_axis_tuser_o  = {out_q.region, out_q.kind};

endmodule

FILE: rtl/core/tsd_checker.sv
`include "tar_stream_deframer_top_defines.svh"

module tsd_checker (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       s_axis_tvalid_i,
  input logic                       s_axis_tready_o,
  input logic [7:0]                 s_axis_tdata_i,
  input logic                       s_axis_tlast_i,
  input logic                       m_axis_tvalid_o,
  input logic                       m_axis_tready_i,
  input logic [tsd_pkg::TDataW-1:0] m_axis_tdata_o,
  input logic [tsd_pkg::TUserW-1:0] m_axis_tuser_o
);
  import tsd_pkg::*;

  logic  hdr_done;
  logic  arc_end;
  logic  is_header;

  assign hdr_done  = m_axis_tdata_o[8];
  assign arc_end   = m_axis_tdata_o[54];
  assign is_header = (m_axis_tuser_o[1:0] == KIND_HEADER);

  // A stalled result transaction holds its contents.
  `TSD_ASSERT(a_stall_hold, m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tuser_o), "result changed while stalled")

  // A header block ends either as an entry or as the archive end, never both.
  `TSD_ASSERT(a_done_excl, m_axis_tvalid_o |-> !(hdr_done && arc_end), "header_done and archive_end together")

  // Only header bytes carry a region or header completion flags.
  `TSD_ASSERT(a_kind_flags, m_axis_tvalid_o && !is_header |-> m_axis_tuser_o[3:2] == REG_OTHER && !hdr_done && !arc_end, "flags on a byte outside a header")

  // A long-name entry is a completed header with type L.
  `TSD_ASSERT(a_long_name, m_axis_tvalid_o && m_axis_tdata_o[53] |-> hdr_done && m_axis_tdata_o[52:45] == ChLong, "long_name without an L header")

endmodule

bind tar_stream_deframer_top tsd_checker u_tsd_checker (.*);
